// ===== sv/bsm_pkg.sv =====
// shared constants and types for the booth signed multiplier
package bsm_pkg;

    // default operand width and fixed port widths
    localparam int OPERAND_WIDTH_DEF = 32;
    localparam int OPERAND_PORT_W    = 32;
    localparam int PRODUCT_PORT_W    = 64;

    // booth recoding of {current low bit, previous bit}
    localparam logic [1:0] BOOTH_ADD = 2'b01;
    localparam logic [1:0] BOOTH_SUB = 2'b10;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic step;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic last_step;
    } t_dp_status;

endpackage

// ===== sv/bsm_ctrl.sv =====
// controller state machine for the booth signed multiplier
module bsm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  bsm_pkg::t_dp_status i_status,
    output bsm_pkg::t_dp_cmd   o_cmd,
    output logic               o_busy,
    output logic               o_done
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    // a beat is taken whenever the datapath is not stepping
    assign accept = i_start && !o_busy;
    assign o_busy = (r_state == ST_RUN);
    assign o_done = (r_state == ST_DONE);

    // datapath commands
    always_comb begin
        o_cmd.load = accept;
        o_cmd.step = (r_state == ST_RUN);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_RUN;
            end
            ST_RUN: begin
                if (i_status.last_step) n_state = ST_DONE;
            end
            ST_DONE: begin
                n_state = accept ? ST_RUN : ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== sv/bsm_datapath.sv =====
// accumulator, shift register and step counter of the booth multiplier
module bsm_datapath #(
    parameter int OPERAND_WIDTH = bsm_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  bsm_pkg::t_dp_cmd                   i_cmd,
    input  logic [bsm_pkg::OPERAND_PORT_W-1:0] i_multiplicand,
    input  logic [bsm_pkg::OPERAND_PORT_W-1:0] i_multiplier,
    output bsm_pkg::t_dp_status                o_status,
    output logic signed [bsm_pkg::PRODUCT_PORT_W-1:0] o_product
);

    localparam int W    = OPERAND_WIDTH;
    localparam int CNTW = $clog2(W + 1);

    localparam logic [1:0] BOOTH_ADD_SEL = bsm_pkg::BOOTH_ADD;
    localparam logic [1:0] BOOTH_SUB_SEL = bsm_pkg::BOOTH_SUB;

    localparam int PRODUCT_W = bsm_pkg::PRODUCT_PORT_W;

    logic [W:0]      r_acc;
    logic [W-1:0]    r_q;
    logic            r_prev;
    logic [W-1:0]    r_mcand;
    logic [CNTW-1:0] r_cnt;

    logic [W:0]      mext;
    logic [W:0]      sum;
    logic [2*W-1:0]  full;

    // multiplicand sign-extended to the accumulator width
    assign mext = {r_mcand[W-1], r_mcand};

    // add or subtract per booth pair
    always_comb begin
        case ({r_q[0], r_prev})
            BOOTH_ADD_SEL: sum = r_acc + mext;
            BOOTH_SUB_SEL: sum = r_acc - mext;
            default:       sum = r_acc;
        endcase
    end

    assign o_status.last_step = (r_cnt == CNTW'(W - 1));

    // low 2w bits of the pair, sign-extended to the port
    assign full      = {r_acc[W-1:0], r_q};
    assign o_product = PRODUCT_W'($signed(full));

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            r_cnt <= '0;
        end else if (i_cmd.step) begin
            r_cnt <= r_cnt + CNTW'(1);
        end
    end

    // operand load and arithmetic shift right of acc:q
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mcand <= '0;
            r_q     <= '0;
            r_acc   <= '0;
            r_prev  <= 1'b0;
        end else if (i_cmd.load) begin
            r_mcand <= i_multiplicand[W-1:0];
            r_q     <= i_multiplier[W-1:0];
            r_acc   <= '0;
            r_prev  <= 1'b0;
        end else if (i_cmd.step) begin
            r_acc  <= {sum[W], sum[W:1]};
            r_q    <= {sum[0], r_q[W-1:1]};
            r_prev <= r_q[0];
        end
    end

endmodule

// ===== sv/booth_signed_multiplier_top.sv =====
// top level of the radix-2 booth signed multiplier
// the accepted start beat loads the datapath; the run state then does one booth add
//   and shift per cycle, and o_done strobes after the last step; no start is taken
//   while busy, and a new start is taken in the done cycle
// reset: synchronous active-low i_rst_n returns the controller to idle, no strobe
// the product is flagged for the single done cycle; the receiver cannot stall
module booth_signed_multiplier_top #(
    parameter int OPERAND_WIDTH = bsm_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      start,
    output logic                                      busy,
    input  logic signed [bsm_pkg::OPERAND_PORT_W-1:0] i_multiplicand,
    input  logic signed [bsm_pkg::OPERAND_PORT_W-1:0] i_multiplier,
    output logic                                      o_done,
    output logic signed [bsm_pkg::PRODUCT_PORT_W-1:0] o_product
);

    bsm_pkg::t_dp_cmd    cmd;
    bsm_pkg::t_dp_status status;

    // controller
    bsm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_done   (o_done)
    );

    // datapath
    bsm_datapath #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_multiplicand (i_multiplicand),
        .i_multiplier   (i_multiplier),
        .o_status       (status),
        .o_product      (o_product)
    );

endmodule

// ===== sv/bsm_checker.sv =====
// port-level checker for the booth signed multiplier, with its bind
module bsm_checker #(
    parameter int OPERAND_WIDTH = bsm_pkg::OPERAND_WIDTH_DEF
) (
    input logic                                      i_clk,
    input logic                                      i_rst_n,
    input logic                                      start,
    input logic                                      busy,
    input logic signed [bsm_pkg::OPERAND_PORT_W-1:0] i_multiplicand,
    input logic signed [bsm_pkg::OPERAND_PORT_W-1:0] i_multiplier,
    input logic                                      o_done,
    input logic signed [bsm_pkg::PRODUCT_PORT_W-1:0] o_product
);

    localparam int W  = OPERAND_WIDTH;
    localparam int PW = bsm_pkg::PRODUCT_PORT_W;

    logic signed [W-1:0]  r_a;
    logic signed [W-1:0]  r_b;
    logic signed [PW-1:0] expected;

    // capture operands of the accepted beat
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_a <= i_multiplicand[W-1:0];
            r_b <= i_multiplier[W-1:0];
        end
    end

    assign expected = PW'(r_a) * PW'(r_b);

    // an accepted beat starts the step sequence
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted beat");

    // the strobe only follows a run of steps
    a_done_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("done without preceding run");

    // the run ends only into a done strobe
    a_run_ends_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("run ended without done");

    // product matches the captured operands
    a_product: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_product == expected))
        else $error("wrong product");

endmodule

bind booth_signed_multiplier_top bsm_checker #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
) u_bsm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_multiplicand (i_multiplicand),
    .i_multiplier   (i_multiplier),
    .o_done         (o_done),
    .o_product      (o_product)
);
